### hdl/lovm_pkg.sv
package lovm_pkg;

    localparam int THREAD_SLOTS_DEF     = 8;
    localparam int LOCKS_PER_THREAD_DEF = 8;

    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;
    localparam int HELD_W   = 4;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ORDER      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LIST_FULL  = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request, start slot search
        logic scan_step;  // compare one slot
        logic walk_start; // begin list walk
        logic walk_step;  // process one list entry
        logic finish;     // commit slot metadata, latch result
    } lovm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic walk_done;
        logic need_walk;
    } lovm_stat_t;

endpackage

### hdl/lovm_ctrl.sv
module lovm_ctrl
    import lovm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output lovm_cmd_t  cmd,
    input  lovm_stat_t stat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_WPRE = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                    state_next = S_WPRE;
            end
            S_WPRE:
            begin
                if (stat.need_walk)
                begin
                    cmd.walk_start = 1'b1;
                    state_next = S_WALK;
                end
                else
                    state_next = S_FIN;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hdl/lovm_dp.sv
module lovm_dp
    import lovm_pkg::*;
#(
    parameter int THREAD_SLOTS     = THREAD_SLOTS_DEF,
    parameter int LOCKS_PER_THREAD = LOCKS_PER_THREAD_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_type,
    input  logic [ID_W-1:0]     thread_id,
    input  logic [ID_W-1:0]     lock_id,
    input  logic [ID_W-1:0]     lock_rank,
    output logic [STATUS_W-1:0] status,
    output logic [HELD_W-1:0]   held_count,
    input  lovm_cmd_t           cmd,
    output lovm_stat_t          stat
);

    localparam int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int EW = (LOCKS_PER_THREAD > 1) ? $clog2(LOCKS_PER_THREAD) : 1;
    localparam int CW = $clog2(LOCKS_PER_THREAD + 1);
    localparam int DEPTH = THREAD_SLOTS << EW;
    localparam int AW = SW + EW;
    localparam int SCW = $clog2(THREAD_SLOTS + 1);

    // held list memory, one entry per slot and position
    logic [ID_W-1:0] mem_lock [DEPTH];
    logic [ID_W-1:0] mem_rank [DEPTH];

    logic [THREAD_SLOTS-1:0] valid_reg;
    logic [ID_W-1:0]         thr_reg [THREAD_SLOTS];
    logic [CW-1:0]           cnt_reg [THREAD_SLOTS];

    logic            req_reg;
    logic [ID_W-1:0] tid_reg, lid_reg, rank_reg;
    logic [SCW-1:0]  scan_reg;
    logic            hit_reg, free_fnd_reg;
    logic [SW-1:0]   hit_slot_reg, free_slot_reg;

    logic [CW-1:0]   rd_reg;  // read position
    logic [CW-1:0]   wr_reg;  // write position / kept count
    logic [ID_W-1:0] prev_rank_reg;
    logic            have_prev_reg, viol_reg;
    logic [ID_W-1:0] rd_lock_reg, rd_rank_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [HELD_W-1:0]   held_reg;

    logic [SW-1:0] scan_idx;
    logic [SW-1:0] slot;
    logic [CW-1:0] n_cur;
    logic          acq_append;
    logic [EW-1:0] rd_pos, wr_pos;
    logic [AW-1:0] rd_addr;
    logic [ID_W-1:0] e_lock, e_rank;

    assign scan_idx = scan_reg[SW-1:0];
    assign slot     = hit_slot_reg;
    assign n_cur    = cnt_reg[slot];
    // acquire on a known thread with room: walk ranks, appending at the list end
    assign acq_append = !req_reg && hit_reg && (n_cur < CW'(LOCKS_PER_THREAD));
    assign rd_pos = rd_reg[EW-1:0];
    assign wr_pos = wr_reg[EW-1:0];
    // fetch one entry ahead of the one being processed
    assign rd_addr = cmd.walk_start ? {slot, EW'(0)} : {slot, rd_pos + EW'(1)};

    assign stat.scan_done = (scan_reg == SCW'(THREAD_SLOTS - 1));
    assign stat.need_walk = hit_reg && (req_reg || acq_append);
    assign stat.walk_done = req_reg ? (rd_reg == n_cur - CW'(1))
                                    : (rd_reg == n_cur);

    // entry under processing, the appended one comes from the request
    always_comb
    begin
        if (!req_reg && rd_reg == n_cur)
        begin
            e_lock = lid_reg;
            e_rank = rank_reg;
        end
        else
        begin
            e_lock = rd_lock_reg;
            e_rank = rd_rank_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req_type;
            tid_reg  <= thread_id;
            lid_reg  <= lock_id;
            rank_reg <= lock_rank;
            hit_reg  <= 1'b0;
            free_fnd_reg <= 1'b0;
            hit_slot_reg <= '0;
            free_slot_reg <= '0;
            scan_reg <= '0;
        end
        if (cmd.scan_step)
        begin
            if (valid_reg[scan_idx] && thr_reg[scan_idx] == tid_reg && !hit_reg)
            begin
                hit_reg <= 1'b1;
                hit_slot_reg <= scan_idx;
            end
            if (!valid_reg[scan_idx] && !free_fnd_reg)
            begin
                free_fnd_reg <= 1'b1;
                free_slot_reg <= scan_idx;
            end
            scan_reg <= scan_reg + SCW'(1);
        end
        if (cmd.walk_start || cmd.walk_step)
        begin
            rd_lock_reg <= mem_lock[rd_addr];
            rd_rank_reg <= mem_rank[rd_addr];
        end
        if (cmd.walk_start)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
            have_prev_reg <= 1'b0;
            viol_reg <= 1'b0;
        end
        if (cmd.walk_step)
        begin
            rd_reg <= rd_reg + CW'(1);
            if (req_reg)
            begin
                if (e_lock != lid_reg)
                begin
                    mem_lock[{slot, wr_pos}] <= e_lock;
                    mem_rank[{slot, wr_pos}] <= e_rank;
                    wr_reg <= wr_reg + CW'(1);
                end
            end
            else
            begin
                if (rd_reg == n_cur)
                begin
                    mem_lock[{slot, rd_pos}] <= lid_reg;
                    mem_rank[{slot, rd_pos}] <= rank_reg;
                end
                if (have_prev_reg && e_rank < prev_rank_reg)
                    viol_reg <= 1'b1;
                prev_rank_reg <= e_rank;
                have_prev_reg <= 1'b1;
            end
        end
        if (cmd.finish && !req_reg && !hit_reg && free_fnd_reg)
        begin
            mem_lock[{free_slot_reg, EW'(0)}] <= lid_reg;
            mem_rank[{free_slot_reg, EW'(0)}] <= rank_reg;
            thr_reg[free_slot_reg] <= tid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < THREAD_SLOTS; i++)
                cnt_reg[i] <= '0;
            status_reg <= ST_OK;
            held_reg <= '0;
        end
        else if (cmd.finish)
        begin
            if (!req_reg)
            begin
                if (!hit_reg)
                begin
                    if (free_fnd_reg)
                    begin
                        valid_reg[free_slot_reg] <= 1'b1;
                        cnt_reg[free_slot_reg] <= CW'(1);
                        status_reg <= ST_OK;
                        held_reg <= HELD_W'(1);
                    end
                    else
                    begin
                        status_reg <= ST_TABLE_FULL;
                        held_reg <= '0;
                    end
                end
                else if (!acq_append)
                begin
                    status_reg <= ST_LIST_FULL;
                    held_reg <= HELD_W'(n_cur);
                end
                else
                begin
                    cnt_reg[slot] <= n_cur + CW'(1);
                    status_reg <= viol_reg ? ST_ORDER : ST_OK;
                    held_reg <= HELD_W'(n_cur + CW'(1));
                end
            end
            else if (!hit_reg)
            begin
                status_reg <= ST_UNKNOWN;
                held_reg <= '0;
            end
            else
            begin
                cnt_reg[slot] <= wr_reg;
                if (wr_reg == '0)
                    valid_reg[slot] <= 1'b0;
                status_reg <= ST_OK;
                held_reg <= HELD_W'(wr_reg);
            end
        end
    end

    assign status = status_reg;
    assign held_count = held_reg;

endmodule

### hdl/lock_order_violation_monitor.sv
// channel | signals                  | payload
// in      | in_valid / in_ready      | req_type, thread_id, lock_id, lock_rank
// out     | out_valid / out_ready    | status, held_count
// one request at a time: accept, search of all THREAD_SLOTS slots, walk setup, list
// walk of up to LOCKS_PER_THREAD entries when needed, commit, result
// the slot search and the held list walk each take one entry per cycle
// the result is held in the output register until transferred
// reset clears all slot valid bits and counts; list storage is not cleared
module lock_order_violation_monitor
    import lovm_pkg::*;
#(
    parameter int THREAD_SLOTS     = THREAD_SLOTS_DEF,
    parameter int LOCKS_PER_THREAD = LOCKS_PER_THREAD_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [ID_W-1:0]     thread_id,
    input  logic [ID_W-1:0]     lock_id,
    input  logic [ID_W-1:0]     lock_rank,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [HELD_W-1:0]   held_count
);

    lovm_cmd_t  cmd;
    lovm_stat_t stat;

    lovm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    lovm_dp #(
        .THREAD_SLOTS     (THREAD_SLOTS),
        .LOCKS_PER_THREAD (LOCKS_PER_THREAD)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_type   (req_type),
        .thread_id  (thread_id),
        .lock_id    (lock_id),
        .lock_rank  (lock_rank),
        .status     (status),
        .held_count (held_count),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule
